[design/c2d_pkg.sv]
package c2d_pkg;

    // command codes
    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_WEIGHT  = 2'd1;
    localparam logic [1:0] CMD_BIAS    = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_KERNEL   = 3'd0;
    localparam logic [2:0] REG_FILTERS  = 3'd1;
    localparam logic [2:0] REG_STRIDE   = 3'd2;
    localparam logic [2:0] REG_PADDING  = 3'd3;
    localparam logic [2:0] REG_CHANNELS = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_WIDTH    = 3'd6;

    // internal widths
    localparam int GW   = 12;   // signed pixel coordinates
    localparam int DIMW = 9;    // capped map dimension
    localparam int CNTW = 7;    // capped channel or filter count
    localparam int AW   = 48;   // accumulator

    typedef logic signed [GW-1:0] coord_t;

    // decoded configuration shared by front and back
    typedef struct packed {
        logic [1:0]      half;
        coord_t          off;
        logic [3:0]      step;
        logic [DIMW-1:0] hgt;
        logic [DIMW-1:0] wid;
        logic [CNTW-1:0] chans;
    } cfg_t;

    // one classified transaction in the queue
    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         f;
        logic [3:0]         c;
        logic [4:0]         r;
        logic [4:0]         k;
        logic signed [15:0] v;
        logic               oor;
        coord_t             cy;
        coord_t             cx;
    } entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_FLUSH,
        B_EMIT
    } back_state_t;

endpackage

[design/conv2d_multichannel_layer.sv]
// multi-channel 2d convolution layer, q8.8 operands, q16.16 results
// input channel: in_valid/in_ready carries one command per transaction:
//   load sample, load weight, load bias (no result) or compute one output
//   position (filter_index, row_index, col_index), which gives one result
// output channel: out_valid/out_ready carries output_value and status
//   (status 1 marks a position outside the output grid or an unused filter, value zero)
// configuration: cfg_write with cfg_index/cfg_data, only while idle
// sequence: a load is written to its store by the back end; a compute runs
//   channel_count * k_eff * k_eff taps through the shared multiply-accumulate
//   (k_eff = kernel_size rounded up to odd), each tap passing through a
//   registered store read, a multiply and an accumulate, then bias and saturation
// an out-of-range compute skips the taps and emits a zero result directly
// a two-entry queue parts the command front end from the compute back end,
//   and the output register lets a new command be taken while a result waits
// if the receiver stalls, the result holds and the back end waits on the
//   next compute; the queue fills and in_ready drops
// reset restores the register defaults and empties the pipeline;
//   store contents are undefined until loaded
module conv2d_multichannel_layer #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_MAP_DIM  = 32,
    parameter int MAX_KERNEL   = 7,
    parameter int MAX_FILTERS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         filter_index,
    input  logic [3:0]         channel_index,
    input  logic [4:0]         row_index,
    input  logic [4:0]         col_index,
    input  logic signed [15:0] load_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] output_value,
    output logic               status
);

    c2d_pkg::cfg_t   cfg;
    c2d_pkg::entry_t push_data;
    c2d_pkg::entry_t pop_data;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    c2d_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_MAP_DIM  (MAX_MAP_DIM),
        .MAX_KERNEL   (MAX_KERNEL),
        .MAX_FILTERS  (MAX_FILTERS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .filter_index  (filter_index),
        .channel_index (channel_index),
        .row_index     (row_index),
        .col_index     (col_index),
        .load_value    (load_value),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_data),
        .cfg           (cfg)
    );

    c2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    c2d_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_MAP_DIM  (MAX_MAP_DIM),
        .MAX_KERNEL   (MAX_KERNEL),
        .MAX_FILTERS  (MAX_FILTERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .output_value (output_value),
        .status       (status)
    );

endmodule

[design/c2d_front.sv]
module c2d_front #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_MAP_DIM  = 32,
    parameter int MAX_KERNEL   = 7,
    parameter int MAX_FILTERS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         filter_index,
    input  logic [3:0]         channel_index,
    input  logic [4:0]         row_index,
    input  logic [4:0]         col_index,
    input  logic signed [15:0] load_value,
    input  logic               q_full,
    output logic               q_push,
    output c2d_pkg::entry_t    q_data,
    output c2d_pkg::cfg_t      cfg
);

    logic [2:0] kernel_size_reg;
    logic [4:0] filter_count_reg;
    logic [3:0] stride_reg;
    logic [1:0] padding_reg;
    logic [4:0] channel_count_reg;
    logic [5:0] map_height_reg;
    logic [5:0] map_width_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg   <= 3'd3;
            filter_count_reg  <= 5'd1;
            stride_reg        <= 4'd1;
            padding_reg       <= 2'd0;
            channel_count_reg <= 5'd1;
            map_height_reg    <= 6'd32;
            map_width_reg     <= 6'd32;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                c2d_pkg::REG_KERNEL:   kernel_size_reg   <= cfg_data[2:0];
                c2d_pkg::REG_FILTERS:  filter_count_reg  <= cfg_data[4:0];
                c2d_pkg::REG_STRIDE:   stride_reg        <= cfg_data[3:0];
                c2d_pkg::REG_PADDING:  padding_reg       <= cfg_data[1:0];
                c2d_pkg::REG_CHANNELS: channel_count_reg <= cfg_data[4:0];
                c2d_pkg::REG_HEIGHT:   map_height_reg    <= cfg_data;
                c2d_pkg::REG_WIDTH:    map_width_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [c2d_pkg::CNTW-1:0] fcnt;

    // decoded, capped configuration
    always_comb
    begin
        cfg.half  = kernel_size_reg[2:1];
        cfg.off   = c2d_pkg::GW'(kernel_size_reg[2:1]) - c2d_pkg::GW'(padding_reg);
        cfg.step  = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
        cfg.hgt   = (32'(map_height_reg) > MAX_MAP_DIM) ? c2d_pkg::DIMW'(MAX_MAP_DIM)
                                                        : c2d_pkg::DIMW'(map_height_reg);
        cfg.wid   = (32'(map_width_reg) > MAX_MAP_DIM) ? c2d_pkg::DIMW'(MAX_MAP_DIM)
                                                       : c2d_pkg::DIMW'(map_width_reg);
        cfg.chans = (32'(channel_count_reg) > MAX_CHANNELS) ? c2d_pkg::CNTW'(MAX_CHANNELS)
                                                            : c2d_pkg::CNTW'(channel_count_reg);
        fcnt      = (32'(filter_count_reg) > MAX_FILTERS) ? c2d_pkg::CNTW'(MAX_FILTERS)
                                                          : c2d_pkg::CNTW'(filter_count_reg);
    end

    logic [8:0]      rs;
    logic [8:0]      ks;
    c2d_pkg::coord_t cy;
    c2d_pkg::coord_t cx;
    logic            on_grid;
    logic            keep;

    // output position and grid check for compute
    assign rs = 9'(row_index) * 9'(cfg.step);
    assign ks = 9'(col_index) * 9'(cfg.step);
    assign cy = cfg.off + c2d_pkg::GW'(rs);
    assign cx = cfg.off + c2d_pkg::GW'(ks);
    assign on_grid = (c2d_pkg::CNTW'(filter_index) < fcnt)
                  && (cy < $signed(c2d_pkg::GW'(cfg.hgt)) - cfg.off)
                  && (cx < $signed(c2d_pkg::GW'(cfg.wid)) - cfg.off);

    // loads outside their store are dropped here
    always_comb
    begin
        case (command)
            c2d_pkg::CMD_SAMPLE:
                keep = (32'(channel_index) < MAX_CHANNELS) && (32'(row_index) < MAX_MAP_DIM)
                    && (32'(col_index) < MAX_MAP_DIM);
            c2d_pkg::CMD_WEIGHT:
                keep = (32'(filter_index) < MAX_FILTERS) && (32'(channel_index) < MAX_CHANNELS)
                    && (32'(row_index) < MAX_KERNEL) && (32'(col_index) < MAX_KERNEL);
            c2d_pkg::CMD_BIAS:
                keep = (32'(filter_index) < MAX_FILTERS);
            default:
                keep = 1'b1;
        endcase
    end

    assign in_ready   = !q_full;
    assign q_push     = in_valid && !q_full && keep;
    assign q_data.cmd = command;
    assign q_data.f   = filter_index;
    assign q_data.c   = channel_index;
    assign q_data.r   = row_index;
    assign q_data.k   = col_index;
    assign q_data.v   = load_value;
    assign q_data.oor = !on_grid;
    assign q_data.cy  = cy;
    assign q_data.cx  = cx;

endmodule

[design/c2d_queue.sv]
module c2d_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  c2d_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output c2d_pkg::entry_t pop_data
);

    c2d_pkg::entry_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // two-entry fifo pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[design/c2d_back.sv]
module c2d_back #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_MAP_DIM  = 32,
    parameter int MAX_KERNEL   = 7,
    parameter int MAX_FILTERS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  c2d_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  c2d_pkg::entry_t     q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  output_value,
    output logic                status
);

    localparam int FDEPTH = MAX_CHANNELS * MAX_MAP_DIM * MAX_MAP_DIM;
    localparam int WDEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int BAW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic signed [15:0] feat_mem [FDEPTH];
    logic signed [15:0] wgt_mem  [WDEPTH];
    logic signed [15:0] bias_mem [MAX_FILTERS];

    c2d_pkg::back_state_t state_reg;
    c2d_pkg::back_state_t state_next;

    logic [3:0]         f_reg;
    c2d_pkg::coord_t    cy_reg;
    c2d_pkg::coord_t    cx_reg;
    logic [CHW-1:0]     ch_reg;
    logic [2:0]         kr_reg;
    logic [2:0]         kc_reg;
    logic               issue_v_reg;
    logic               prod_v_reg;
    logic signed [15:0] feat_rd_reg;
    logic signed [15:0] wgt_rd_reg;
    logic signed [15:0] bias_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [c2d_pkg::AW-1:0] acc_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic               status_reg;

    logic               out_free;
    logic               start;
    logic               emit_oor;
    logic               emit_sum;
    logic               issue;
    logic               last_tap;
    logic [2:0]         kmax;
    c2d_pkg::coord_t    ty;
    c2d_pkg::coord_t    tx;
    logic               tap_ok;
    logic [FAW-1:0]     rd_faddr;
    logic [WAW-1:0]     rd_waddr;
    logic [FAW-1:0]     wr_faddr;
    logic [WAW-1:0]     wr_waddr;
    logic               wr_feat;
    logic               wr_wgt;
    logic               wr_bias;
    logic signed [c2d_pkg::AW-1:0] total;
    logic signed [31:0] sat;

    assign out_free = !out_valid_reg || out_ready;
    assign kmax     = {cfg.half, 1'b0};
    assign last_tap = (c2d_pkg::CNTW'(ch_reg) == cfg.chans - 1'b1)
                   && (kr_reg == kmax) && (kc_reg == kmax);

    // tap position and validity
    assign ty = cy_reg + c2d_pkg::GW'(kr_reg) - c2d_pkg::GW'(cfg.half);
    assign tx = cx_reg + c2d_pkg::GW'(kc_reg) - c2d_pkg::GW'(cfg.half);
    assign tap_ok = (ty >= 0) && (ty < $signed(c2d_pkg::GW'(cfg.hgt)))
                 && (tx >= 0) && (tx < $signed(c2d_pkg::GW'(cfg.wid)))
                 && (32'(kr_reg) < MAX_KERNEL) && (32'(kc_reg) < MAX_KERNEL);

    assign rd_faddr = FAW'((int'(ch_reg) * MAX_MAP_DIM + int'(ty[c2d_pkg::DIMW-1:0]))
                          * MAX_MAP_DIM + int'(tx[c2d_pkg::DIMW-1:0]));
    assign rd_waddr = WAW'(((int'(f_reg) * MAX_CHANNELS + int'(ch_reg)) * MAX_KERNEL
                          + int'(kr_reg)) * MAX_KERNEL + int'(kc_reg));
    assign wr_faddr = FAW'((int'(q_data.c) * MAX_MAP_DIM + int'(q_data.r))
                          * MAX_MAP_DIM + int'(q_data.k));
    assign wr_waddr = WAW'(((int'(q_data.f) * MAX_CHANNELS + int'(q_data.c)) * MAX_KERNEL
                          + int'(q_data.r)) * MAX_KERNEL + int'(q_data.k));

    // sequencer next state and controls
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        start      = 1'b0;
        emit_oor   = 1'b0;
        emit_sum   = 1'b0;
        issue      = 1'b0;
        wr_feat    = 1'b0;
        wr_wgt     = 1'b0;
        wr_bias    = 1'b0;
        case (state_reg)
            c2d_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_data.cmd)
                        c2d_pkg::CMD_SAMPLE:
                        begin
                            wr_feat = 1'b1;
                            q_pop   = 1'b1;
                        end
                        c2d_pkg::CMD_WEIGHT:
                        begin
                            wr_wgt = 1'b1;
                            q_pop  = 1'b1;
                        end
                        c2d_pkg::CMD_BIAS:
                        begin
                            wr_bias = 1'b1;
                            q_pop   = 1'b1;
                        end
                        default:
                        begin
                            if (q_data.oor)
                            begin
                                if (out_free)
                                begin
                                    emit_oor = 1'b1;
                                    q_pop    = 1'b1;
                                end
                            end
                            else
                            begin
                                start = 1'b1;
                                q_pop = 1'b1;
                                state_next = (cfg.chans == '0) ? c2d_pkg::B_FLUSH
                                                               : c2d_pkg::B_RUN;
                            end
                        end
                    endcase
                end
            end
            c2d_pkg::B_RUN:
            begin
                issue = 1'b1;
                if (last_tap)
                    state_next = c2d_pkg::B_FLUSH;
            end
            c2d_pkg::B_FLUSH:
            begin
                if (!issue_v_reg && !prod_v_reg)
                    state_next = c2d_pkg::B_EMIT;
            end
            c2d_pkg::B_EMIT:
            begin
                if (out_free)
                begin
                    emit_sum   = 1'b1;
                    state_next = c2d_pkg::B_IDLE;
                end
            end
            default:
                state_next = c2d_pkg::B_IDLE;
        endcase
    end

    // bias add and saturation
    assign total = acc_reg + (c2d_pkg::AW'(bias_rd_reg) <<< 8);
    assign sat   = (total > c2d_pkg::AW'(32'sh7fffffff)) ? 32'sh7fffffff :
                   (total < -(c2d_pkg::AW'(33'sh080000000))) ? 32'sh80000000 :
                   total[31:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= c2d_pkg::B_IDLE;
            issue_v_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_v_reg <= issue && tap_ok;
            prod_v_reg  <= issue_v_reg;
            if (emit_oor || emit_sum)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // tap counters, multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            f_reg   <= q_data.f;
            cy_reg  <= q_data.cy;
            cx_reg  <= q_data.cx;
            ch_reg  <= '0;
            kr_reg  <= 3'd0;
            kc_reg  <= 3'd0;
            acc_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                if (kc_reg == kmax)
                begin
                    kc_reg <= 3'd0;
                    if (kr_reg == kmax)
                    begin
                        kr_reg <= 3'd0;
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else
                        kr_reg <= kr_reg + 3'd1;
                end
                else
                    kc_reg <= kc_reg + 3'd1;
            end
            if (prod_v_reg)
                acc_reg <= acc_reg + c2d_pkg::AW'(prod_reg);
        end
        prod_reg <= feat_rd_reg * wgt_rd_reg;
        if (emit_oor)
        begin
            out_value_reg <= 32'sd0;
            status_reg    <= 1'b1;
        end
        else if (emit_sum)
        begin
            out_value_reg <= sat;
            status_reg    <= 1'b0;
        end
    end

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_feat)
            feat_mem[wr_faddr] <= q_data.v;
        feat_rd_reg <= feat_mem[rd_faddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_wgt)
            wgt_mem[wr_waddr] <= q_data.v;
        wgt_rd_reg <= wgt_mem[rd_waddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_bias)
            bias_mem[BAW'(q_data.f)] <= q_data.v;
        bias_rd_reg <= bias_mem[BAW'(f_reg)];
    end

    assign out_valid    = out_valid_reg;
    assign output_value = out_value_reg;
    assign status       = status_reg;

    // checks on the tap pipeline and result register
    a_prod_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        issue_v_reg |=> prod_v_reg)
        else $error("product stage lost a tap");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == c2d_pkg::B_EMIT) |-> (!issue_v_reg && !prod_v_reg))
        else $error("result emitted with taps in flight");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (out_value_reg == 32'sd0))
        else $error("out-of-range result carries a value");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> (!emit_oor && !emit_sum))
        else $error("pending result overwritten");

endmodule
